[sv/cbd_pkg.sv]
// Shared types and constants for the covalent bond detector.
// Used by cbd_pair_test and covalent_bond_detector; depends on nothing.
package cbd_pkg;

  // Field widths, fixed by the stream format
  localparam int unsigned COORD_W = 20;
  localparam int unsigned RAD_W   = 12;
  localparam int unsigned TOL_W   = 10;
  localparam int unsigned IDX_W   = 6;

  // Datapath widths
  localparam int unsigned RSUM_W  = RAD_W + 1;        // r0 + r1
  localparam int unsigned PROD_W  = TOL_W + RSUM_W;   // tolerance * (r0 + r1)
  localparam int unsigned LHS_W   = 2 * PROD_W;       // squared bond limit
  localparam int unsigned SQ_W    = 2 * COORD_W;      // one squared axis delta
  localparam int unsigned D2_W    = SQ_W + 2;         // sum of three squares
  localparam int unsigned D2S_SH  = 16;               // scale of distance term
  localparam int unsigned CMP_W   = D2_W + D2S_SH;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(256);

  // One stored atom
  typedef struct packed {
    logic [RAD_W-1:0]   radius;
    logic [COORD_W-1:0] pos_z;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_x;
  } atom_t;

  // Tag that travels down the compare pipeline
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } tag_t;

  // Per-item control flow
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

endpackage

[sv/cbd_pair_test.sv]
// Two-stage pipelined pair test: axis deltas and radius limit, then squares,
// then the bond compare. Depends on cbd_pkg.
module cbd_pair_test
  import cbd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,        // pipeline advance
  input  tag_t             tag_i,       // beat of read data below
  input  atom_t            stored_i,    // registered memory read data
  input  atom_t            new_i,       // atom being placed
  input  logic [TOL_W-1:0] tol_i,
  output tag_t             tag_o,
  output logic             hit_o,
  output logic             busy_o       // any stage holds a beat
);

  // Stage A registers
  tag_t               a_tag_q;
  logic [COORD_W-1:0] a_dx_q, a_dy_q, a_dz_q;
  logic [PROD_W-1:0]  a_p_q;

  // Stage B registers
  tag_t               b_tag_q;
  logic [SQ_W-1:0]    b_sqx_q, b_sqy_q, b_sqz_q;
  logic [LHS_W-1:0]   b_lhs_q;

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    logic [COORD_W:0] n;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    n = -d;
    return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
  endfunction

  // Stage A combinational
  logic [RSUM_W-1:0] rsum;
  logic [PROD_W-1:0] p_d;
  always_comb begin
    rsum = {1'b0, new_i.radius} + {1'b0, stored_i.radius};
    p_d  = PROD_W'(tol_i) * PROD_W'(rsum);
  end

  // Tags, with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_tag_q <= '0;
      b_tag_q <= '0;
    end else if (en_i) begin
      a_tag_q <= tag_i;
      b_tag_q <= a_tag_q;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_dx_q      <= abs_diff(new_i.pos_x, stored_i.pos_x);
      a_dy_q      <= abs_diff(new_i.pos_y, stored_i.pos_y);
      a_dz_q      <= abs_diff(new_i.pos_z, stored_i.pos_z);
      a_p_q       <= p_d;
      b_sqx_q     <= SQ_W'(a_dx_q) * SQ_W'(a_dx_q);
      b_sqy_q     <= SQ_W'(a_dy_q) * SQ_W'(a_dy_q);
      b_sqz_q     <= SQ_W'(a_dz_q) * SQ_W'(a_dz_q);
      b_lhs_q     <= LHS_W'(a_p_q) * LHS_W'(a_p_q);
    end
  end

  // Bond compare on stage B
  logic [D2_W-1:0] d2;
  always_comb begin
    d2    = D2_W'(b_sqx_q) + D2_W'(b_sqy_q) + D2_W'(b_sqz_q);
    hit_o = CMP_W'(b_lhs_q) > {d2, {D2S_SH{1'b0}}};
  end

  assign tag_o  = b_tag_q;
  assign busy_o = a_tag_q.valid | b_tag_q.valid;

endmodule

[sv/covalent_bond_detector.sv]
// Top level of the covalent bond detector: atom store, scan control and
// result register. Depends on cbd_pkg and cbd_pair_test.
//
// Each accepted atom is compared with the atoms already stored for the
// current molecule, one stored atom per cycle while the output is not
// stalled, read from a single-port synchronous memory into a registered
// read stage and a two-stage compare pipeline. The last result beat of an
// atom is loaded into the output register by the finish step after its
// scan; an overflow atom goes to that step with no scan. The input is ready
// again right after that last beat is loaded, so the block takes no new atom
// before then; the length of the scan and any output stalls set how long
// one atom occupies it. Results for bonded pairs come out in increasing
// partner order, the last one marked by tlast; an atom with no bond gives one
// empty beat. A start flag in tuser clears the molecule. Once MAX_ATOMS atoms
// are stored, further atoms give one overflow beat and are dropped. The store
// needs no clearing pass.
module covalent_bond_detector
  import cbd_pkg::*;
#(
  parameter int unsigned MAX_ATOMS = 64   // 2 .. 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // tolerance register, unsigned Q2.8
  input  logic              cfg_we_i,
  input  logic [TOL_W-1:0]  cfg_wdata_i,
  // atom input
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [71:0]       s_axis_tdata,   // pos_x, pos_y, pos_z, radius
  input  logic              s_axis_tuser,   // start_req
  // result output
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // self_index, partner_index, zeros
  output logic [1:0]        m_axis_tuser,   // found, overflow
  output logic              m_axis_tlast
);

  localparam int unsigned AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ATOMS + 1);

  // Registers
  state_e             state_q, state_d;
  logic [TOL_W-1:0]   tol_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      n_q;
  logic [CW-1:0]      idx_q;
  logic               ovf_q;
  atom_t              new_q;
  logic               pend_valid_q;
  logic [IDX_W-1:0]   pend_idx_q;
  tag_t               rd_tag_q;
  atom_t              rdata_q;
  logic               out_valid_q;
  logic [IDX_W-1:0]   out_self_q, out_partner_q;
  logic               out_found_q, out_ovf_q, out_last_q;

  atom_t              mem [MAX_ATOMS];

  // Control wires
  logic               in_fire;
  logic               advance;
  logic               issue;
  logic               scan_done;
  logic               finish_fire;
  logic               hit_fire;
  logic               start_req;
  atom_t              in_atom;
  logic [CW-1:0]      n_in;
  logic               ovf_in;
  tag_t               pt_tag;
  logic               pt_hit;
  logic               pt_busy;
  tag_t               issue_tag;

  // Input unpack
  always_comb begin
    start_req      = s_axis_tuser;
    in_atom.pos_x  = s_axis_tdata[19:0];
    in_atom.pos_y  = s_axis_tdata[39:20];
    in_atom.pos_z  = s_axis_tdata[59:40];
    in_atom.radius = s_axis_tdata[71:60];
    n_in           = start_req ? '0 : count_q;
    ovf_in         = n_in >= CW'(MAX_ATOMS);
  end

  assign advance   = !out_valid_q || m_axis_tready;
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign scan_done = (idx_q == n_q) && !rd_tag_q.valid && !pt_busy;
  assign hit_fire  = advance && pt_tag.valid && pt_hit;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire) state_d = ovf_in ? ST_FINISH : ST_SCAN;
      ST_SCAN:   if (scan_done) state_d = ST_FINISH;
      ST_FINISH: if (advance) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    finish_fire   = 1'b0;
    unique case (state_q)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_SCAN:   issue = advance && (idx_q < n_q);
      ST_FINISH: finish_fire = advance;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Atom count, scan counter and per-item context
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      n_q          <= '0;
      idx_q        <= '0;
      ovf_q        <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        n_q          <= n_in;
        idx_q        <= '0;
        ovf_q        <= ovf_in;
        pend_valid_q <= 1'b0;
        if (!ovf_in) begin
          count_q <= n_in + CW'(1);
        end else begin
          count_q <= n_in;
        end
      end else begin
        if (issue) begin
          idx_q <= idx_q + CW'(1);
        end
        if (hit_fire) begin
          pend_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      new_q <= in_atom;
    end
    if (hit_fire) begin
      pend_idx_q <= pt_tag.idx;
    end
  end

  // Atom store: write the new atom, read one stored atom per scan step
  always_ff @(posedge clk_i) begin
    if (in_fire && !ovf_in) begin
      mem[n_in[AW-1:0]] <= in_atom;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rdata_q <= mem[idx_q[AW-1:0]];
    end
  end

  always_comb begin
    issue_tag.valid = issue;
    issue_tag.idx   = IDX_W'(idx_q);
  end

  // Read stage tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_tag_q <= '0;
    end else if (advance) begin
      rd_tag_q <= issue_tag;
    end
  end

  // Compare pipeline
  cbd_pair_test u_pair_test (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .tag_i    (rd_tag_q),
    .stored_i (rdata_q),
    .new_i    (new_q),
    .tol_i    (tol_q),
    .tag_o    (pt_tag),
    .hit_o    (pt_hit),
    .busy_o   (pt_busy)
  );

  // Result register: a bond is held back one step so the final one gets tlast
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((hit_fire && pend_valid_q) || finish_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_fire && pend_valid_q) begin
      out_self_q    <= IDX_W'(n_q);
      out_partner_q <= pend_idx_q;
      out_found_q   <= 1'b1;
      out_ovf_q     <= 1'b0;
      out_last_q    <= 1'b0;
    end else if (finish_fire) begin
      out_last_q <= 1'b1;
      priority if (ovf_q) begin
        out_self_q    <= '0;
        out_partner_q <= '0;
        out_found_q   <= 1'b0;
        out_ovf_q     <= 1'b1;
      end else if (pend_valid_q) begin
        out_self_q    <= IDX_W'(n_q);
        out_partner_q <= pend_idx_q;
        out_found_q   <= 1'b1;
        out_ovf_q     <= 1'b0;
      end else begin
        out_self_q    <= IDX_W'(n_q);
        out_partner_q <= '0;
        out_found_q   <= 1'b0;
        out_ovf_q     <= 1'b0;
      end
    end
  end

  // Output pack
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_partner_q, out_self_q};
  assign m_axis_tuser  = {out_ovf_q, out_found_q};
  assign m_axis_tlast  = out_last_q;

endmodule
